// File: sv/mm64_pkg.sv
package mm64_pkg;

  localparam logic [63:0] MixMult  = 64'hc6a4a7935bd1e995;
  localparam int          MixShift = 47;
  localparam logic [3:0]  FullWord = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_DISPATCH,
    S_K1,
    S_K2,
    S_H,
    S_AV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    xorshift = v ^ (v >> MixShift);
  endfunction

endpackage

// File: sv/mm64_mul.sv
// Low 64 bits of operand * MixMult, built from three 32x32 partial products
// on one multiplier; result is valid with done.
module mm64_mul (
  input  logic                clk,
  input  logic                rst,
  input  mm64_pkg::mul_req_t  req,
  output logic                done,
  output logic [63:0]         result
);

  localparam logic [31:0] MultLo = mm64_pkg::MixMult[31:0];
  localparam logic [31:0] MultHi = mm64_pkg::MixMult[63:32];

  logic        busy;
  logic [1:0]  step;
  logic [63:0] a;
  logic [63:0] prod_q;
  logic [63:0] lo_q;
  logic [31:0] hi_q;
  logic [31:0] x;
  logic [31:0] y;

  always_comb begin
    unique case (step)
      2'd0: begin
        x = a[31:0];
        y = MultLo;
      end
      2'd1: begin
        x = a[63:32];
        y = MultLo;
      end
      default: begin
        x = a[31:0];
        y = MultHi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.operand;
    end else if (busy) begin
      prod_q <= {32'd0, x} * {32'd0, y};
      unique case (step)
        2'd0: ;
        2'd1: lo_q <= prod_q;
        2'd2: hi_q <= lo_q[63:32] + prod_q[31:0];
        default: result <= {hi_q + prod_q[31:0], lo_q[31:0]};
      endcase
    end
  end

endmodule

// File: sv/murmur64a_hash.sv
// One word in flight: s_tready is high only while idle, so the next word waits
// until the current one is done. Each 64-bit constant multiply holds the shared
// 32x32 multiplier. Per word: one multiply for the length on a message's first
// word, then three for a full word or one for a tail, plus one for the avalanche
// at a message's end and a load of the output register, delayed while it is full.
// Reset (rst, synchronous): seed 0, no message open, output empty.
module murmur64a_hash (
  input  logic          clk,
  input  logic          rst,
  // configuration: seed
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [103:0]  s_tdata,  // data_word[63:0], valid_bytes[67:64],
                                  // total_length[98:68], zero[103:99]
  input  logic          s_tlast,  // last_word
  // output stream
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata   // hash_value[63:0]
);

  mm64_pkg::state_t   state;
  mm64_pkg::state_t   state_next;
  mm64_pkg::mul_req_t mul_req;
  logic               mul_done;
  logic [63:0]        mul_res;

  logic [31:0] seed;
  logic [63:0] running_hash;
  logic        in_message;
  logic [63:0] h;
  logic [63:0] word;
  logic [3:0]  nvalid;
  logic        ends;

  logic [63:0] in_word;
  logic [3:0]  in_nvalid;
  logic        accept;
  logic        out_free;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign in_nvalid = s_tdata[67] ? mm64_pkg::FullWord : s_tdata[67:64];

  // drop bytes beyond the valid count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_word[8*i +: 8] = (4'(i) < in_nvalid) ? s_tdata[8*i +: 8] : 8'd0;
    end
  end

  mm64_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mm64_pkg::S_IDLE:
        if (accept) begin
          state_next = in_message ? mm64_pkg::S_DISPATCH : mm64_pkg::S_LEN;
        end
      mm64_pkg::S_LEN:
        if (mul_done) state_next = mm64_pkg::S_DISPATCH;
      mm64_pkg::S_DISPATCH:
        if (nvalid == mm64_pkg::FullWord) state_next = mm64_pkg::S_K1;
        else if (nvalid != 4'd0)          state_next = mm64_pkg::S_H;
        else                              state_next = mm64_pkg::S_AV;
      mm64_pkg::S_K1:
        if (mul_done) state_next = mm64_pkg::S_K2;
      mm64_pkg::S_K2:
        if (mul_done) state_next = mm64_pkg::S_H;
      mm64_pkg::S_H:
        if (mul_done) state_next = ends ? mm64_pkg::S_AV : mm64_pkg::S_IDLE;
      mm64_pkg::S_AV:
        if (mul_done) state_next = mm64_pkg::S_OUT;
      mm64_pkg::S_OUT:
        if (out_free) state_next = mm64_pkg::S_IDLE;
      default:
        state_next = mm64_pkg::S_IDLE;
    endcase
  end

  // issue the next multiply on the way into each multiply state
  always_comb begin
    s_tready        = (state == mm64_pkg::S_IDLE);
    mul_req.start   = 1'b0;
    mul_req.operand = 64'd0;
    unique case (state)
      mm64_pkg::S_IDLE: begin
        mul_req.start   = accept && !in_message;
        mul_req.operand = {33'd0, s_tdata[98:68]};
      end
      mm64_pkg::S_DISPATCH: begin
        mul_req.start = 1'b1;
        if (nvalid == mm64_pkg::FullWord) mul_req.operand = word;
        else if (nvalid != 4'd0)          mul_req.operand = h ^ word;
        else                              mul_req.operand = mm64_pkg::xorshift(h);
      end
      mm64_pkg::S_K1: begin
        mul_req.start   = mul_done;
        mul_req.operand = mm64_pkg::xorshift(mul_res);
      end
      mm64_pkg::S_K2: begin
        mul_req.start   = mul_done;
        mul_req.operand = h ^ mul_res;
      end
      mm64_pkg::S_H: begin
        mul_req.start   = mul_done && ends;
        mul_req.operand = mm64_pkg::xorshift(mul_res);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mm64_pkg::S_IDLE;
      seed         <= 32'd0;
      running_hash <= 64'd0;
      in_message   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) seed <= cfg_data;
      if (state == mm64_pkg::S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == mm64_pkg::S_H && mul_done && !ends) begin
        running_hash <= mul_res;
        in_message   <= 1'b1;
      end
      if (state == mm64_pkg::S_OUT && out_free) begin
        running_hash <= 64'd0;
        in_message   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word   <= in_word;
      nvalid <= in_nvalid;
      ends   <= s_tlast || (in_nvalid != mm64_pkg::FullWord);
      h      <= running_hash;
    end
    if (state == mm64_pkg::S_LEN && mul_done) begin
      h <= {32'd0, seed} ^ mul_res;
    end
    if (state == mm64_pkg::S_H && mul_done) begin
      h <= mul_res;
    end
    if (state == mm64_pkg::S_AV && mul_done) begin
      h <= mm64_pkg::xorshift(mul_res);
    end
    if (state == mm64_pkg::S_OUT && out_free) begin
      m_tdata <= h;
    end
  end

endmodule
